@@ src/nearest_stop_table_search_core_defines.svh @@
`ifndef NEAREST_STOP_TABLE_SEARCH_CORE_DEFINES_SVH
`define NEAREST_STOP_TABLE_SEARCH_CORE_DEFINES_SVH

// same-cycle implication check
`define NSTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nsts check failed");

// next-cycle implication check
`define NSTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nsts check failed");

`endif

@@ src/nsts_pkg.sv @@
// ----------------------------------------------------------------------------
// nsts_pkg
// Shared constants, types and helpers of the nearest stop table search.
// ----------------------------------------------------------------------------
package nsts_pkg;

  localparam int unsigned NSTS_MAX_STOPS  = 64;
  // registered stages between a table read and the running-best update
  localparam int unsigned NSTS_PIPE_DEPTH = 3;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic [15:0]        map;
    logic [31:0]        shaft;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } nsts_entry_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic load_query;
    logic rd_en;
    logic p2_init;
    logic out_load;
  } nsts_cmd_t;

  typedef struct packed {
    logic near_found;
    logic count_zero;
  } nsts_status_t;

  function automatic logic [24:0] abs_diff24(logic [23:0] a, logic [23:0] b);
    logic [24:0] d;
    d = {a[23], a} - {b[23], b};
    return d[24] ? (~d + 25'd1) : d;
  endfunction

endpackage

@@ src/nsts_ctrl.sv @@
// ----------------------------------------------------------------------------
// nsts_ctrl
// Sequencer: decodes requests, walks the table once per query (twice when
// a nearest stop is found) and hands the result to the output channel.
// ----------------------------------------------------------------------------
`include "nearest_stop_table_search_core_defines.svh"

module nsts_ctrl
  import nsts_pkg::*;
#(
  parameter int unsigned MAX_STOPS = NSTS_MAX_STOPS,
  localparam int unsigned IW = $clog2(MAX_STOPS),
  localparam int unsigned CW = $clog2(MAX_STOPS + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_operation,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  logic [CW-1:0]   stop_count,
  input  nsts_status_t    status,
  output nsts_cmd_t       cmd,
  output logic [IW-1:0]   rd_addr
);

  typedef enum logic [2:0] {
    IDLE, SCAN1, DRAIN1, INIT2, SCAN2, DRAIN2, DONE
  } state_t;

  state_t        state_r;
  logic [CW-1:0] idx_r;
  logic [1:0]    dcnt_r;
  logic          out_valid_r;
  logic          accept;
  logic          scan_last;

  assign in_ready  = (state_r == IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign rd_addr   = idx_r[IW-1:0];
  assign scan_last = (idx_r == stop_count - CW'(1));

  always_comb begin
    cmd            = '0;
    cmd.clear      = accept && (in_operation == OP_CLEAR);
    cmd.append     = accept && (in_operation == OP_APPEND);
    cmd.load_query = accept && (in_operation == OP_QUERY);
    cmd.rd_en      = (state_r == SCAN1) || (state_r == SCAN2);
    cmd.p2_init    = (state_r == INIT2);
    cmd.out_load   = (state_r == DONE) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      idx_r       <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        IDLE: begin
          idx_r <= '0;
          if (cmd.load_query) begin
            state_r <= status.count_zero ? DONE : SCAN1;
          end
        end
        SCAN1: begin
          if (scan_last) begin
            dcnt_r  <= 2'(NSTS_PIPE_DEPTH);
            state_r <= DRAIN1;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        DRAIN1: begin
          dcnt_r <= dcnt_r - 2'd1;
          if (dcnt_r == 2'd0) begin
            state_r <= status.near_found ? INIT2 : DONE;
          end
        end
        INIT2: begin
          idx_r   <= '0;
          state_r <= SCAN2;
        end
        SCAN2: begin
          if (scan_last) begin
            dcnt_r  <= 2'(NSTS_PIPE_DEPTH);
            state_r <= DRAIN2;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        DRAIN2: begin
          dcnt_r <= dcnt_r - 2'd1;
          if (dcnt_r == 2'd0) begin
            state_r <= DONE;
          end
        end
        DONE: begin
          if (cmd.out_load) begin
            state_r <= IDLE;
          end
        end
        default: begin
          state_r <= IDLE;
        end
      endcase
    end
  end

  `NSTS_ASSERT_NOW(a_rd_in_table, clk, rst_n, cmd.rd_en, idx_r < stop_count)
  `NSTS_ASSERT_NOW(a_pass2_needs_hit, clk, rst_n, state_r == INIT2, status.near_found)
  `NSTS_ASSERT_NEXT(a_out_from_done, clk, rst_n, !out_valid_r && (state_r != DONE),
                    !out_valid_r)

endmodule

@@ src/nsts_dp.sv @@
// ----------------------------------------------------------------------------
// nsts_dp
// Stop table memory, fill count, distance pipeline and running-best
// registers for both search passes, plus the result register.
// ----------------------------------------------------------------------------
`include "nearest_stop_table_search_core_defines.svh"

module nsts_dp
  import nsts_pkg::*;
#(
  parameter int unsigned MAX_STOPS = NSTS_MAX_STOPS,
  localparam int unsigned IW = $clog2(MAX_STOPS),
  localparam int unsigned CW = $clog2(MAX_STOPS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  nsts_cmd_t          cmd,
  input  logic [IW-1:0]      rd_addr,
  input  logic [15:0]        in_map_id,
  input  logic [31:0]        in_shaft_id,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_pos_z,
  input  logic signed [23:0] in_target_z,
  input  logic [15:0]        in_planar_range,
  input  logic [15:0]        in_height_band,
  output nsts_status_t       status,
  output logic [CW-1:0]      stop_count,
  output logic               out_floor_found,
  output logic [5:0]         out_floor_slot,
  output logic               out_nearest_found,
  output logic [5:0]         out_nearest_slot,
  output logic [5:0]         out_lowest_slot,
  output logic signed [23:0] out_toward_z,
  output logic [6:0]         out_map_stop_count,
  output logic               out_overflow
);

  // table
  nsts_entry_t mem [MAX_STOPS];
  nsts_entry_t rd_data_r;
  logic [CW-1:0] stop_count_r;
  logic          dropped_r;
  logic          full;
  logic          mem_we;

  // query operands
  logic [15:0]        q_map_r;
  logic [23:0]        q_x_r, q_y_r, q_z_r, q_tz_r;
  logic [15:0]        q_band_r;
  logic               pass2_r;

  // pipeline
  logic               s1_valid_r;
  logic [IW-1:0]      s1_idx_r;
  logic               s2_valid_r, s2_match_r, s2_shaft_hit_r, s2_inband_r;
  logic [IW-1:0]      s2_idx_r;
  logic [24:0]        s2_adx_r, s2_ady_r, s2_dz_r;
  logic [31:0]        s2_shaft_r;
  logic signed [23:0] s2_z_r;
  logic               s3_valid_r, s3_match_r, s3_shaft_hit_r, s3_inband_r;
  logic [IW-1:0]      s3_idx_r;
  logic [49:0]        s3_sqx_r, s3_sqy_r;
  logic [24:0]        s3_dz_r;
  logic [31:0]        s3_shaft_r;
  logic signed [23:0] s3_z_r;
  logic [50:0]        plane_dsq;

  // running bests
  logic               near_found_r, floor_found_r;
  logic [IW-1:0]      near_slot_r, floor_slot_r, low_slot_r;
  logic [50:0]        best_near_r, best_floor_r;
  logic [31:0]        near_shaft_r;
  logic signed [23:0] near_z_r, low_z_r, toward_r;
  logic [24:0]        best_dz_r;
  logic [CW-1:0]      map_count_r;

  // zero-extended views for the fixed-width result fields
  logic [IW+5:0]      floor_slot_ext, near_slot_ext, low_slot_ext;
  logic [CW+6:0]      map_count_ext;

  assign full       = (stop_count_r == CW'(MAX_STOPS));
  assign mem_we     = cmd.append && !full;
  assign stop_count = stop_count_r;
  assign status.near_found = near_found_r;
  assign status.count_zero = (stop_count_r == '0);
  assign plane_dsq  = {1'b0, s3_sqx_r} + {1'b0, s3_sqy_r};

  assign floor_slot_ext = {6'd0, floor_slot_r};
  assign near_slot_ext  = {6'd0, near_slot_r};
  assign low_slot_ext   = {6'd0, low_slot_r};
  assign map_count_ext  = {7'd0, map_count_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[stop_count_r[IW-1:0]] <= '{map: in_map_id, shaft: in_shaft_id,
                                     x: in_pos_x, y: in_pos_y, z: in_pos_z};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_count_r <= '0;
      dropped_r    <= 1'b0;
    end else if (cmd.clear) begin
      stop_count_r <= '0;
      dropped_r    <= 1'b0;
    end else if (cmd.append) begin
      if (full) begin
        dropped_r <= 1'b1;
      end else begin
        stop_count_r <= stop_count_r + CW'(1);
      end
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      pass2_r    <= 1'b0;
    end else begin
      s1_valid_r <= cmd.rd_en;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      if (cmd.load_query) begin
        pass2_r <= 1'b0;
      end else if (cmd.p2_init) begin
        pass2_r <= 1'b1;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      q_map_r  <= in_map_id;
      q_x_r    <= in_pos_x;
      q_y_r    <= in_pos_y;
      q_z_r    <= in_pos_z;
      q_tz_r   <= in_target_z;
      q_band_r <= in_height_band;
    end
    s1_idx_r       <= rd_addr;
    s2_idx_r       <= s1_idx_r;
    s2_match_r     <= (rd_data_r.map == q_map_r);
    s2_shaft_hit_r <= (rd_data_r.shaft == near_shaft_r);
    s2_adx_r       <= abs_diff24(rd_data_r.x, q_x_r);
    s2_ady_r       <= abs_diff24(rd_data_r.y, q_y_r);
    s2_inband_r    <= (abs_diff24(rd_data_r.z, q_z_r) <= {9'd0, q_band_r});
    s2_dz_r        <= abs_diff24(rd_data_r.z, q_tz_r);
    s2_shaft_r     <= rd_data_r.shaft;
    s2_z_r         <= rd_data_r.z;
    s3_idx_r       <= s2_idx_r;
    s3_match_r     <= s2_match_r;
    s3_shaft_hit_r <= s2_shaft_hit_r;
    s3_inband_r    <= s2_inband_r;
    s3_sqx_r       <= 50'(s2_adx_r) * 50'(s2_adx_r);
    s3_sqy_r       <= 50'(s2_ady_r) * 50'(s2_ady_r);
    s3_dz_r        <= s2_dz_r;
    s3_shaft_r     <= s2_shaft_r;
    s3_z_r         <= s2_z_r;
  end

  // found flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_found_r  <= 1'b0;
      floor_found_r <= 1'b0;
    end else if (cmd.load_query) begin
      near_found_r  <= 1'b0;
      floor_found_r <= 1'b0;
    end else if (s3_valid_r && !pass2_r && s3_match_r) begin
      if (plane_dsq < best_near_r) begin
        near_found_r <= 1'b1;
      end
      if (s3_inband_r && (plane_dsq < best_floor_r)) begin
        floor_found_r <= 1'b1;
      end
    end
  end

  // running bests for both passes
  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      best_near_r  <= 51'(32'(in_planar_range) * 32'(in_planar_range));
      best_floor_r <= 51'(32'(in_planar_range) * 32'(in_planar_range));
      near_slot_r  <= '0;
      floor_slot_r <= '0;
      low_slot_r   <= '0;
      toward_r     <= '0;
      map_count_r  <= '0;
    end else if (cmd.p2_init) begin
      low_slot_r <= near_slot_r;
      low_z_r    <= near_z_r;
      best_dz_r  <= '1;
    end else if (s3_valid_r && !pass2_r && s3_match_r) begin
      map_count_r <= map_count_r + CW'(1);
      if (plane_dsq < best_near_r) begin
        best_near_r  <= plane_dsq;
        near_slot_r  <= s3_idx_r;
        near_shaft_r <= s3_shaft_r;
        near_z_r     <= s3_z_r;
      end
      if (s3_inband_r && (plane_dsq < best_floor_r)) begin
        best_floor_r <= plane_dsq;
        floor_slot_r <= s3_idx_r;
      end
    end else if (s3_valid_r && pass2_r && s3_match_r && s3_shaft_hit_r) begin
      // lowest stop of the shaft, ties keep the nearest stop
      if (s3_z_r < low_z_r) begin
        low_slot_r <= s3_idx_r;
        low_z_r    <= s3_z_r;
      end
      if (s3_dz_r < best_dz_r) begin
        best_dz_r <= s3_dz_r;
        toward_r  <= s3_z_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_floor_found    <= floor_found_r;
      out_floor_slot     <= floor_slot_ext[5:0];
      out_nearest_found  <= near_found_r;
      out_nearest_slot   <= near_slot_ext[5:0];
      out_lowest_slot    <= low_slot_ext[5:0];
      out_toward_z       <= toward_r;
      out_map_stop_count <= map_count_ext[6:0];
      out_overflow       <= dropped_r;
    end
  end

  `NSTS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, stop_count_r <= CW'(MAX_STOPS))
  `NSTS_ASSERT_NOW(a_floor_implies_near, clk, rst_n, floor_found_r, near_found_r)
  `NSTS_ASSERT_NOW(a_pass2_after_hit, clk, rst_n, s3_valid_r && pass2_r, near_found_r)

endmodule

@@ src/nearest_stop_table_search_core.sv @@
// ----------------------------------------------------------------------------
// nearest_stop_table_search_core
// Brute-force nearest elevator stop search over a table of stops.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request channel (valid/ready). in_operation selects clear table,
//           append stop or query; code 3 is taken and ignored.
//   out_* : one result per query (valid/ready), nothing for other requests.
//   Clear and append complete in the accept cycle and are taken back to back.
//   A query reads the stop table once per cycle through a single read port:
//   one pass over all stored stops for the nearest stops, a second pass over
//   the same stops for the nearest stop's shaft if one was found; an empty
//   table is not read at all. in_ready stays low until the result is loaded
//   into the output register.
//   The result sits in an output register: while the receiver stalls, clear
//   and append requests are still taken; a following query runs and then
//   waits for the register to free up.
//   Reset empties the table and clears the overflow flag; table contents are
//   not cleared, entries beyond the fill count are never read.
// ----------------------------------------------------------------------------
module nearest_stop_table_search_core
  import nsts_pkg::*;
#(
  parameter int unsigned MAX_STOPS = NSTS_MAX_STOPS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [15:0]        in_map_id,
  input  logic [31:0]        in_shaft_id,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_pos_z,
  input  logic signed [23:0] in_target_z,
  input  logic [15:0]        in_planar_range,
  input  logic [15:0]        in_height_band,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_floor_found,
  output logic [5:0]         out_floor_slot,
  output logic               out_nearest_found,
  output logic [5:0]         out_nearest_slot,
  output logic [5:0]         out_lowest_slot,
  output logic signed [23:0] out_toward_z,
  output logic [6:0]         out_map_stop_count,
  output logic               out_overflow
);

  localparam int unsigned IW = $clog2(MAX_STOPS);
  localparam int unsigned CW = $clog2(MAX_STOPS + 1);

  nsts_cmd_t     cmd;
  nsts_status_t  status;
  logic [IW-1:0] rd_addr;
  logic [CW-1:0] stop_count;

  nsts_ctrl #(
    .MAX_STOPS (MAX_STOPS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stop_count   (stop_count),
    .status       (status),
    .cmd          (cmd),
    .rd_addr      (rd_addr)
  );

  nsts_dp #(
    .MAX_STOPS (MAX_STOPS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .rd_addr            (rd_addr),
    .in_map_id          (in_map_id),
    .in_shaft_id        (in_shaft_id),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .in_target_z        (in_target_z),
    .in_planar_range    (in_planar_range),
    .in_height_band     (in_height_band),
    .status             (status),
    .stop_count         (stop_count),
    .out_floor_found    (out_floor_found),
    .out_floor_slot     (out_floor_slot),
    .out_nearest_found  (out_nearest_found),
    .out_nearest_slot   (out_nearest_slot),
    .out_lowest_slot    (out_lowest_slot),
    .out_toward_z       (out_toward_z),
    .out_map_stop_count (out_map_stop_count),
    .out_overflow       (out_overflow)
  );

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest stop table search core. Clear, append
// and query requests go in through a valid/ready channel while an in-bench
// copy of the stop table predicts each query answer. Answers are compared
// field by field in order. Traffic runs through directed corner cases, a
// table overflow, long result back-pressure and clustered random scenes
// under changing idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import nsts_pkg::*;

  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int          CLK_HALF     = 5;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 2 * NSTS_MAX_STOPS + 60;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int          FLOOR_STEP   = 160;

  typedef struct packed {
    logic [1:0]         op;
    logic [15:0]        map;
    logic [31:0]        shaft;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic signed [23:0] tz;
    logic [15:0]        reach;
    logic [15:0]        band;
  } stop_request_t;

  typedef struct packed {
    logic        floor_found;
    logic [5:0]  floor_slot;
    logic        nearest_found;
    logic [5:0]  nearest_slot;
    logic [5:0]  lowest_slot;
    logic [23:0] toward_z;
    logic [6:0]  stop_count;
    logic        overflow;
  } stop_answer_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_operation = OP_CLEAR;
  logic [15:0]        in_map_id = '0;
  logic [31:0]        in_shaft_id = '0;
  logic signed [23:0] in_pos_x = '0;
  logic signed [23:0] in_pos_y = '0;
  logic signed [23:0] in_pos_z = '0;
  logic signed [23:0] in_target_z = '0;
  logic [15:0]        in_planar_range = '0;
  logic [15:0]        in_height_band = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_floor_found;
  logic [5:0]         out_floor_slot;
  logic               out_nearest_found;
  logic [5:0]         out_nearest_slot;
  logic [5:0]         out_lowest_slot;
  logic signed [23:0] out_toward_z;
  logic [6:0]         out_map_stop_count;
  logic               out_overflow;

  // bench copy of the stop table
  nsts_entry_t  stop_table [NSTS_MAX_STOPS];
  int unsigned  table_fill = 0;
  logic         table_dropped = 1'b0;
  stop_answer_t pending_answers [$];

  int unsigned requests_sent = 0;
  int unsigned clears_taken = 0;
  int unsigned appends_taken = 0;
  int unsigned appends_dropped = 0;
  int unsigned queries_taken = 0;
  int unsigned ignored_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_request = 0;

  // current random scene: one cluster of shafts around a center
  int          scene_cx, scene_cy, scene_cz, scene_shafts;
  logic [15:0] scene_maps [3];
  logic [31:0] shaft_ids [6];
  int          shaft_x [6];
  int          shaft_y [6];
  int          shaft_home [6];

  nearest_stop_table_search_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_map_id          (in_map_id),
    .in_shaft_id        (in_shaft_id),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .in_target_z        (in_target_z),
    .in_planar_range    (in_planar_range),
    .in_height_band     (in_height_band),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_floor_found    (out_floor_found),
    .out_floor_slot     (out_floor_slot),
    .out_nearest_found  (out_nearest_found),
    .out_nearest_slot   (out_nearest_slot),
    .out_lowest_slot    (out_lowest_slot),
    .out_toward_z       (out_toward_z),
    .out_map_stop_count (out_map_stop_count),
    .out_overflow       (out_overflow)
  );

  always #CLK_HALF clk = ~clk;

  function automatic longint unsigned span(input logic signed [23:0] a,
                                           input logic signed [23:0] b);
    longint diff;
    diff = longint'(a) - longint'(b);
    return (diff < 0) ? -diff : diff;
  endfunction

  function automatic stop_answer_t search_table(input stop_request_t r);
    stop_answer_t       a;
    longint unsigned    reach2, best_floor, best_near, best_dz, dx, dy, d, dz;
    int unsigned        near_idx, floor_idx, low_idx, count;
    logic               found_near, found_floor;
    logic signed [23:0] toward;
    reach2 = 64'(r.reach);
    reach2 = reach2 * reach2;
    best_floor = reach2;
    best_near = reach2;
    found_near = 1'b0;
    found_floor = 1'b0;
    near_idx = 0;
    floor_idx = 0;
    low_idx = 0;
    count = 0;
    toward = '0;
    for (int i = 0; i < table_fill; i++) begin
      if (stop_table[i].map == r.map) begin
        count++;
        dx = span(stop_table[i].x, r.x);
        dy = span(stop_table[i].y, r.y);
        d = dx * dx + dy * dy;
        // strict less-than keeps the earlier slot on a tie
        if (d < best_near) begin
          best_near = d;
          near_idx = i;
          found_near = 1'b1;
        end
        if (span(stop_table[i].z, r.z) <= r.band && d < best_floor) begin
          best_floor = d;
          floor_idx = i;
          found_floor = 1'b1;
        end
      end
    end
    if (found_near) begin
      low_idx = near_idx;
      best_dz = '1;
      for (int i = 0; i < table_fill; i++) begin
        if (stop_table[i].map == r.map &&
            stop_table[i].shaft == stop_table[near_idx].shaft) begin
          if ($signed(stop_table[i].z) < $signed(stop_table[low_idx].z)) low_idx = i;
          dz = span(stop_table[i].z, r.tz);
          if (dz < best_dz) begin
            best_dz = dz;
            toward = stop_table[i].z;
          end
        end
      end
    end
    a.floor_found = found_floor;
    a.floor_slot = floor_idx[5:0];
    a.nearest_found = found_near;
    a.nearest_slot = near_idx[5:0];
    a.lowest_slot = low_idx[5:0];
    a.toward_z = toward;
    a.stop_count = count[6:0];
    a.overflow = table_dropped;
    return a;
  endfunction

  function automatic void apply_request(input stop_request_t r);
    case (r.op)
      OP_CLEAR: begin
        table_fill = 0;
        table_dropped = 1'b0;
        clears_taken++;
      end
      OP_APPEND: begin
        appends_taken++;
        if (table_fill >= NSTS_MAX_STOPS) begin
          table_dropped = 1'b1;
          appends_dropped++;
        end else begin
          stop_table[table_fill] = '{map: r.map, shaft: r.shaft, x: r.x, y: r.y, z: r.z};
          table_fill++;
        end
      end
      OP_QUERY: begin
        queries_taken++;
        pending_answers.insert(pending_answers.size(), search_table(r));
      end
      default: ignored_taken++;
    endcase
  endfunction

  task automatic compare_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("  mismatch in result %0d, %s: expected 0x%0h got 0x%0h",
                 results_seen, label, want, got);
    end
  endtask

  task automatic check_answer(input stop_answer_t got);
    stop_answer_t want;
    results_seen++;
    if (pending_answers.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("  result %0d arrived with no query pending", results_seen);
      return;
    end
    want = pending_answers.pop_front();
    compare_field("floor_found", 32'(want.floor_found), 32'(got.floor_found));
    compare_field("floor_slot", 32'(want.floor_slot), 32'(got.floor_slot));
    compare_field("nearest_found", 32'(want.nearest_found), 32'(got.nearest_found));
    compare_field("nearest_slot", 32'(want.nearest_slot), 32'(got.nearest_slot));
    compare_field("lowest_slot", 32'(want.lowest_slot), 32'(got.lowest_slot));
    compare_field("toward_z", 32'(want.toward_z), 32'(got.toward_z));
    compare_field("map_stop_count", 32'(want.stop_count), 32'(got.stop_count));
    compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
  endtask

  // results are checked before the same-edge request is predicted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        check_answer(stop_answer_t'{
          floor_found: out_floor_found, floor_slot: out_floor_slot,
          nearest_found: out_nearest_found, nearest_slot: out_nearest_slot,
          lowest_slot: out_lowest_slot, toward_z: out_toward_z,
          stop_count: out_map_stop_count, overflow: out_overflow});
      if (in_valid && in_ready)
        apply_request(stop_request_t'{
          op: in_operation, map: in_map_id, shaft: in_shaft_id,
          x: in_pos_x, y: in_pos_y, z: in_pos_z, tz: in_target_z,
          reach: in_planar_range, band: in_height_band});
    end
  end

  initial begin : receiver
    int unsigned held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        held = hold_request;
        hold_request = 0;
      end
      if (held != 0) begin
        out_ready <= 1'b0;
        held--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("  no handshake for %0d cycles", STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_request(input stop_request_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= r.op;
    in_map_id       <= r.map;
    in_shaft_id     <= r.shaft;
    in_pos_x        <= r.x;
    in_pos_y        <= r.y;
    in_pos_z        <= r.z;
    in_target_z     <= r.tz;
    in_planar_range <= r.reach;
    in_height_band  <= r.band;
    do @(posedge clk); while (!in_ready);
    if (r.op != OP_UNUSED) requests_sent++;
  endtask

  function automatic stop_request_t pack_request(input logic [1:0] op,
      input logic [15:0] map, input logic [31:0] shaft, input int x, input int y,
      input int z, input int tz, input logic [15:0] reach, input logic [15:0] band);
    stop_request_t r;
    r.op = op;
    r.map = map;
    r.shaft = shaft;
    r.x = 24'(x);
    r.y = 24'(y);
    r.z = 24'(z);
    r.tz = 24'(tz);
    r.reach = reach;
    r.band = band;
    return r;
  endfunction

  function automatic stop_request_t random_request(input logic [1:0] op);
    stop_request_t r;
    r.op = op;
    r.map = 16'($urandom());
    r.shaft = $urandom();
    r.x = 24'($urandom());
    r.y = 24'($urandom());
    r.z = 24'($urandom());
    r.tz = 24'($urandom());
    r.reach = 16'($urandom());
    r.band = 16'($urandom());
    return r;
  endfunction

  task automatic setup_scene();
    scene_cx = int'($urandom_range(16000000)) - 8000000;
    scene_cy = int'($urandom_range(16000000)) - 8000000;
    scene_cz = int'($urandom_range(4000000)) - 2000000;
    scene_shafts = $urandom_range(1, 6);
    for (int k = 0; k < 3; k++) scene_maps[k] = 16'($urandom());
    if ($urandom_range(3) == 0) scene_maps[0] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    for (int s = 0; s < 6; s++) begin
      shaft_ids[s] = $urandom();
      shaft_x[s] = scene_cx + int'($urandom_range(6000)) - 3000;
      shaft_y[s] = scene_cy + int'($urandom_range(6000)) - 3000;
      shaft_home[s] = $urandom_range(2);
    end
    // same shaft id on two shafts, so the shaft pass has to filter by map too
    if ($urandom_range(2) == 0) shaft_ids[1] = shaft_ids[0];
  endtask

  function automatic stop_request_t scene_stop();
    stop_request_t r;
    int            s;
    r = random_request(OP_APPEND);
    s = $urandom_range(scene_shafts - 1);
    r.map = ($urandom_range(4) == 0) ? scene_maps[$urandom_range(2)]
                                     : scene_maps[shaft_home[s]];
    r.shaft = shaft_ids[s];
    r.x = 24'(shaft_x[s] + (($urandom_range(3) == 0) ? int'($urandom_range(8)) - 4 : 0));
    r.y = 24'(shaft_y[s] + (($urandom_range(3) == 0) ? int'($urandom_range(8)) - 4 : 0));
    r.z = 24'(scene_cz + FLOOR_STEP * int'($urandom_range(7)) +
              (($urandom_range(3) == 0) ? int'($urandom_range(40)) - 20 : 0));
    return r;
  endfunction

  function automatic stop_request_t scene_query();
    stop_request_t r;
    int            s;
    r = random_request(OP_QUERY);
    s = $urandom_range(scene_shafts - 1);
    if ($urandom_range(9) != 0) r.map = scene_maps[$urandom_range(2)];
    if ($urandom_range(4) == 0) begin
      r.x = 24'(shaft_x[s]);
      r.y = 24'(shaft_y[s]);
    end else if ($urandom_range(9) != 0) begin
      r.x = 24'(scene_cx + int'($urandom_range(8000)) - 4000);
      r.y = 24'(scene_cy + int'($urandom_range(8000)) - 4000);
    end
    if ($urandom_range(6) != 0)
      r.z = 24'(scene_cz + FLOOR_STEP * int'($urandom_range(7)) +
                int'($urandom_range(80)) - 40);
    if ($urandom_range(3) != 0)
      r.tz = 24'(scene_cz + FLOOR_STEP * int'($urandom_range(8)) +
                 int'($urandom_range(200)) - 100);
    case ($urandom_range(9))
      0: r.reach = 16'h0000;
      1: r.reach = 16'hFFFF;
      2: ;
      default: r.reach = 16'($urandom_range(200, 8000));
    endcase
    case ($urandom_range(9))
      0: r.band = 16'h0000;
      1: r.band = 16'hFFFF;
      2: ;
      default: r.band = 16'($urandom_range(400));
    endcase
    return r;
  endfunction

  task automatic test_directed();
    send_request(pack_request(OP_QUERY, 16'd0, 32'd0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF));
    send_request(pack_request(OP_APPEND, 16'd7, 32'd100, 0, 0, 0, 0, 0, 0));
    send_request(pack_request(OP_APPEND, 16'd7, 32'd100, 0, 0, -160, 0, 0, 0));
    send_request(pack_request(OP_APPEND, 16'd7, 32'd200, 16, 0, 320, 0, 0, 0));
    send_request(pack_request(OP_APPEND, 16'd7, 32'd200, 0, 16, 320, 0, 0, 0));
    // same shaft id on another map
    send_request(pack_request(OP_APPEND, 16'd9, 32'd100, 0, 0, -320, 0, 0, 0));
    send_request(pack_request(OP_APPEND, 16'd7, 32'd100, 0, 0, -160, 0, 0, 0));
    send_request(pack_request(OP_APPEND, 16'hFFFF, 32'hFFFF_FFFF,
                              8388607, -8388608, 8388607, 0, 0, 0));
    send_request(pack_request(OP_APPEND, 16'hFFFF, 32'h0,
                              -8388608, 8388607, -8388608, 0, 0, 0));
    // target halfway between two floors, lowest-stop height tie
    send_request(pack_request(OP_QUERY, 16'd7, 32'd0, 0, 0, 0, -80, 16'd32, 16'd0));
    // five stops at equal planar distance
    send_request(pack_request(OP_QUERY, 16'd7, 32'd0, 8, 8, 320, 8388607, 16'd32, 16'd16));
    // zero range with a stop right under the querier
    send_request(pack_request(OP_QUERY, 16'd7, 32'd0, 0, 0, 0, 0, 16'd0, 16'hFFFF));
    send_request(pack_request(OP_QUERY, 16'd7, 32'd0, 16, 0, 0, -8388608, 16'd1, 16'hFFFF));
    send_request(pack_request(OP_QUERY, 16'hFFFF, 32'hFFFF_FFFF, 8388607, -8388608,
                              8388607, -8388608, 16'hFFFF, 16'hFFFF));
    send_request(pack_request(OP_QUERY, 16'hFFFF, 32'd0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF));
    send_request(pack_request(OP_QUERY, 16'h1234, 32'd0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF));
    send_request(pack_request(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, -1, -1, -1, -1,
                              16'hFFFF, 16'hFFFF));
    send_request(pack_request(OP_QUERY, 16'd7, 32'd0, 0, 0, -160, -160, 16'hFFFF, 16'd0));
    send_request(pack_request(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, -1, -1, -1, -1,
                              16'hFFFF, 16'hFFFF));
    send_request(pack_request(OP_QUERY, 16'd7, 32'd0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF));
  endtask

  task automatic test_full_table();
    setup_scene();
    send_request(random_request(OP_CLEAR));
    repeat (NSTS_MAX_STOPS + 3) send_request(scene_stop());
    repeat (3) send_request(scene_query());
    send_request(scene_stop());
    send_request(scene_query());
    // overflow flag must drop with the clear
    send_request(random_request(OP_CLEAR));
    send_request(scene_query());
  endtask

  task automatic test_back_pressure();
    setup_scene();
    hold_request = HOLD_CYCLES;
    send_request(random_request(OP_CLEAR));
    repeat (12) send_request(scene_stop());
    repeat (6) begin
      send_request(scene_query());
      repeat (2) send_request(scene_stop());
    end
  endtask

  task automatic test_random_scenes(input int unsigned budget);
    int unsigned stop_at;
    int          n;
    logic [1:0]  op;
    stop_at = requests_sent + budget;
    while (requests_sent < stop_at) begin
      setup_scene();
      if ($urandom_range(9) != 0) send_request(random_request(OP_CLEAR));
      case ($urandom_range(19))
        0: n = $urandom_range(65, 72);
        1, 2, 3: n = $urandom_range(25, 64);
        default: n = $urandom_range(1, 24);
      endcase
      repeat (n) begin
        send_request(scene_stop());
        if ($urandom_range(11) == 0) send_request(scene_query());
        // stray request with fully random fields
        if ($urandom_range(29) == 0) begin
          case ($urandom_range(2))
            0: op = OP_UNUSED;
            1: op = OP_QUERY;
            default: op = OP_APPEND;
          endcase
          send_request(random_request(op));
        end
      end
      repeat ($urandom_range(1, 5)) send_request(scene_query());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 6;
    rx_idle_pct = 76;
    test_directed();
    test_full_table();
    test_random_scenes(520);

    tx_idle_pct = 76;
    rx_idle_pct = 6;
    test_back_pressure();
    test_random_scenes(520);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_scenes(520);

    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_answers.size() != 0) begin
      mismatches += pending_answers.size();
      $display("  %0d query answers never arrived", pending_answers.size());
    end

    $display("covered %0d requests: %0d clears, %0d appends (%0d dropped when full), %0d queries",
             requests_sent, clears_taken, appends_taken, appends_dropped, queries_taken);
    $display("%0d answers compared, %0d unused-opcode requests, %0d mismatches",
             results_seen, ignored_taken, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
